// ===== rtl/bounded_byte_stream_fifo_defines.svh =====
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO assertion macros
// Shared property wrappers for clocked checks with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_DEFINES_SVH
`define BOUNDED_BYTE_STREAM_FIFO_DEFINES_SVH

// check under reset gating
`define BBSF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bbsf check failed");

// check at every edge, reset included
`define BBSF_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bbsf check failed");

`endif

// ===== rtl/bbsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO package
// Word types, opcode codes and fixed field widths.
// ----------------------------------------------------------------------------
package bbsf_pkg;

  localparam int CAP_W = 13;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [1:0] OPC_WRITE = 2'd0;
  localparam logic [1:0] OPC_POP   = 2'd1;
  localparam logic [1:0] OPC_PEEK  = 2'd2;
  localparam logic [1:0] OPC_END   = 2'd3;

  typedef enum logic [3:0] {
    OP_WRITE = 4'b0001,
    OP_POP   = 4'b0010,
    OP_PEEK  = 4'b0100,
    OP_END   = 4'b1000
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [12:0] pop_count;
    logic [11:0] peek_index;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  peek_data;
    logic        range_error;
    logic [12:0] buffered;
    logic [12:0] room_left;
    logic [31:0] written_total;
    logic [31:0] read_total;
    logic        input_closed;
    logic        stream_done;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data_byte;
    logic [12:0] pop_count;
    logic [11:0] peek_index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== rtl/bbsf_front.sv =====
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO front end
// Accepts input words, decodes the opcode and queues commands for the back end.
// ----------------------------------------------------------------------------
module bbsf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bbsf_pkg::in_item_t in_data_i,
  output bbsf_pkg::q_head_t  head_o,
  input  logic               pop_i
);
  import bbsf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.data_byte  = in_data_i.data_byte;
    cmd_in.pop_count  = in_data_i.pop_count;
    cmd_in.peek_index = in_data_i.peek_index;
    case (in_data_i.opcode)
      OPC_WRITE: cmd_in.op = OP_WRITE;
      OPC_POP:   cmd_in.op = OP_POP;
      OPC_PEEK:  cmd_in.op = OP_PEEK;
      OPC_END:   cmd_in.op = OP_END;
      default:   cmd_in.op = OP_END;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/bbsf_back.sv =====
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO back end
// Executes queued commands against the byte store and registers each result.
// ----------------------------------------------------------------------------
module bbsf_back #(
  parameter int DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [12:0]         cfg_data_i,
  input  bbsf_pkg::q_head_t   head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bbsf_pkg::out_item_t out_data_o
);
  import bbsf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (PW > CAP_W) ? PW : CAP_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_PEEK = 2'b10
  } bk_state_e;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_q;
  bk_state_e        state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    held_q, held_d;
  logic [31:0]      written_q, written_d;
  logic [31:0]      read_q, read_d;
  logic             ended_q, ended_d;
  logic             out_valid_q;
  out_item_t        out_q, res;

  logic          out_free, exec, wr_ok, pop_err, peek_err, rd_en, load;
  logic [XW-1:0] held_x, cnt_x, idx_x, cap_x, eff_x, held_n_x, room_x;
  logic [PW-1:0] tail_sum, pop_sum, peek_sum;
  logic [AW-1:0] tail_addr, pop_addr, peek_addr;

  assign out_free = !out_valid_q || out_ready_i;
  assign exec     = (state_q == ST_RUN) && head_i.valid && out_free;

  assign held_x = XW'(held_q);
  assign cnt_x  = XW'(head_i.cmd.pop_count);
  assign idx_x  = XW'(head_i.cmd.peek_index);
  assign cap_x  = XW'(cap_q);
  assign eff_x  = (cap_x < DEPTH_X) ? cap_x : DEPTH_X;

  assign wr_ok    = exec && (head_i.cmd.op == OP_WRITE) && (held_x < eff_x);
  assign pop_err  = exec && (head_i.cmd.op == OP_POP) && (cnt_x > held_x);
  assign peek_err = exec && (head_i.cmd.op == OP_PEEK) && (idx_x >= held_x);
  assign rd_en    = exec && (head_i.cmd.op == OP_PEEK) && !peek_err;

  assign tail_sum  = {1'b0, head_q} + held_x[PW-1:0];
  assign pop_sum   = {1'b0, head_q} + cnt_x[PW-1:0];
  assign peek_sum  = {1'b0, head_q} + idx_x[PW-1:0];
  assign tail_addr = (tail_sum >= DEPTH_P) ? AW'(tail_sum - DEPTH_P) : tail_sum[AW-1:0];
  assign pop_addr  = (pop_sum >= DEPTH_P) ? AW'(pop_sum - DEPTH_P) : pop_sum[AW-1:0];
  assign peek_addr = (peek_sum >= DEPTH_P) ? AW'(peek_sum - DEPTH_P) : peek_sum[AW-1:0];

  always_comb begin
    head_d    = head_q;
    held_d    = held_q;
    written_d = written_q;
    read_d    = read_q;
    ended_d   = ended_q;
    if (wr_ok) begin
      held_d    = held_q + CW'(1);
      written_d = written_q + 32'd1;
    end
    if (exec && (head_i.cmd.op == OP_POP) && !pop_err) begin
      head_d = pop_addr;
      held_d = held_q - cnt_x[CW-1:0];
      read_d = read_q + 32'(head_i.cmd.pop_count);
    end
    if (exec && (head_i.cmd.op == OP_END)) begin
      ended_d = 1'b1;
    end
  end

  assign held_n_x = XW'(held_d);
  assign room_x   = (held_n_x < eff_x) ? (eff_x - held_n_x) : '0;

  always_comb begin
    res.accepted      = wr_ok;
    res.peek_data     = (state_q == ST_PEEK) ? rd_q : 8'd0;
    res.range_error   = pop_err || peek_err;
    res.buffered      = held_n_x[CAP_W-1:0];
    res.room_left     = room_x[CAP_W-1:0];
    res.written_total = written_d;
    res.read_total    = read_d;
    res.input_closed  = ended_d;
    res.stream_done   = ended_d && (held_d == '0);
  end

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (rd_en) begin
          state_d = ST_PEEK;
        end else if (exec) begin
          load = 1'b1;
        end
      end
      ST_PEEK: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  assign pop_o       = exec;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      held_q      <= '0;
      written_q   <= '0;
      read_q      <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      held_q    <= held_d;
      written_q <= written_d;
      read_q    <= read_d;
      ended_q   <= ended_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[tail_addr] <= head_i.cmd.data_byte;
    end
    if (rd_en) begin
      rd_q <= mem[peek_addr];
    end
  end

endmodule

// ===== rtl/bounded_byte_stream_fifo.sv =====
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO
// Byte FIFO with capacity register, pop, peek and end-of-input marking.
//
//   channel  direction  handshake                  word
//   in       in         in_valid_i / in_ready_o    bbsf_pkg::in_item_t
//   out      out        out_valid_o / out_ready_i  bbsf_pkg::out_item_t
//   cfg      in         cfg_valid_i / cfg_ready_o  capacity, 13 bits
//
// A peek passes through the extra ST_PEEK state in the back end, set by the
// registered read port of the byte store; write, pop and end words do not.
// A two-word queue separates the front end from the back end.
// Reset clears pointers, counters and flags; the byte store is not cleared.
// The result register loads while the previous result is being taken.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo #(
  parameter int DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bbsf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bbsf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [12:0]         cfg_data_i
);
  import bbsf_pkg::*;
  `include "bounded_byte_stream_fifo_defines.svh"

  q_head_t head;
  logic    pop;

  assign cfg_ready_o = 1'b1;

  bbsf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  bbsf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `BBSF_ASSERT(a_pop_needs_head, clk_i, rst_ni, pop |-> head.valid)
  `BBSF_ASSERT(a_full_has_head, clk_i, rst_ni, !in_ready_o |-> head.valid)
  `BBSF_ASSERT(a_done_implies_closed, clk_i, rst_ni,
    (out_valid_o && out_data_o.stream_done) |-> out_data_o.input_closed)
  `BBSF_ASSERT_ALWAYS(a_accept_no_error, clk_i,
    out_valid_o |-> !(out_data_o.accepted && out_data_o.range_error))

endmodule

// ===== dv/bounded_byte_stream_fifo_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded byte stream FIFO testbench
// Drives command words (write, pop, peek, end input) and capacity updates
// through valid/ready channels, with random idling on both sides and one long
// receiver hold-off. Every status word is checked field by field against a
// behavioral model of the byte stream, or against a hand-written value for
// the first rows of the directed table.
// ----------------------------------------------------------------------------
module bounded_byte_stream_fifo_tb;
  import bbsf_pkg::*;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PARK_CYCLES = 400;
  localparam int unsigned RING_SIZE   = 16;
  localparam int unsigned PLAN_SIZE   = 32;

  typedef struct {
    bit          is_cfg;
    logic [12:0] cap;
    in_item_t    word;
    bit          pinned;
    out_item_t   want;
  } row_t;

  typedef struct {
    bit        on;
    out_item_t want;
  } pin_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i  = '0;

  // stream model state
  logic [7:0]  byte_mem [STORE_DEPTH];
  int unsigned head_ptr  = 0;
  int unsigned held_n    = 0;
  logic [31:0] wr_total  = '0;
  logic [31:0] rd_total  = '0;
  bit          closed_f  = 1'b0;
  int unsigned cap_reg   = 4096;

  out_item_t   awaited_status [RING_SIZE];
  int unsigned aw_head  = 0;
  int unsigned aw_tail  = 0;
  int unsigned aw_count = 0;
  pin_t        pinned_slots [RING_SIZE];
  int unsigned pin_wr   = 0;
  int unsigned pin_rd   = 0;
  row_t        plan_rows [PLAN_SIZE];
  int unsigned plan_n   = 0;

  // stimulus planning
  int unsigned gen_held  = 0;
  int unsigned gen_lim   = 4096;
  bit          gaps_on   = 1'b1;
  bit          park_req  = 1'b0;
  int unsigned park_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_n   = 0;
  int unsigned mismatches = 0;

  bounded_byte_stream_fifo #(
    .DEPTH(STORE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_item_t stream_step(in_item_t w);
    out_item_t   r;
    int unsigned lim;
    r   = '0;
    lim = (cap_reg < STORE_DEPTH) ? cap_reg : STORE_DEPTH;
    case (w.opcode)
      OPC_WRITE: begin
        if (held_n < lim) begin
          byte_mem[(head_ptr + held_n) % STORE_DEPTH] = w.data_byte;
          held_n++;
          wr_total++;
          r.accepted = 1'b1;
        end
      end
      OPC_POP: begin
        if (w.pop_count > held_n) begin
          r.range_error = 1'b1;
        end else begin
          head_ptr = (head_ptr + w.pop_count) % STORE_DEPTH;
          held_n   -= w.pop_count;
          rd_total += 32'(w.pop_count);
        end
      end
      OPC_PEEK: begin
        if (w.peek_index >= held_n) begin
          r.range_error = 1'b1;
        end else begin
          r.peek_data = byte_mem[(head_ptr + w.peek_index) % STORE_DEPTH];
        end
      end
      OPC_END: begin
        closed_f = 1'b1;
      end
      default: ;
    endcase
    r.buffered      = 13'(held_n);
    r.room_left     = 13'((held_n < lim) ? lim - held_n : 0);
    r.written_total = wr_total;
    r.read_total    = rd_total;
    r.input_closed  = closed_f;
    r.stream_done   = closed_f && (held_n == 0);
    return r;
  endfunction

  function automatic in_item_t word(logic [1:0] op, logic [7:0] d, logic [12:0] n,
                                    logic [11:0] k);
    in_item_t w;
    w.opcode     = op;
    w.data_byte  = d;
    w.pop_count  = n;
    w.peek_index = k;
    return w;
  endfunction

  function automatic out_item_t status(bit acc, logic [7:0] pk, bit err, int unsigned bufd,
                                       int unsigned room, logic [31:0] wt, logic [31:0] rt,
                                       bit ic, bit sd);
    out_item_t s;
    s.accepted      = acc;
    s.peek_data     = pk;
    s.range_error   = err;
    s.buffered      = 13'(bufd);
    s.room_left     = 13'(room);
    s.written_total = wt;
    s.read_total    = rt;
    s.input_closed  = ic;
    s.stream_done   = sd;
    return s;
  endfunction

  function automatic row_t plain(in_item_t w);
    row_t r;
    r = '{is_cfg: 1'b0, cap: '0, word: w, pinned: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t pinned(in_item_t w, out_item_t s);
    row_t r;
    r = '{is_cfg: 1'b0, cap: '0, word: w, pinned: 1'b1, want: s};
    return r;
  endfunction

  function automatic row_t cap_row(logic [12:0] v);
    row_t r;
    r = '{is_cfg: 1'b1, cap: v, word: '0, pinned: 1'b0, want: '0};
    return r;
  endfunction

  function automatic void add_row(row_t r);
    plan_rows[plan_n] = r;
    plan_n++;
  endfunction

  function automatic in_item_t pick_word();
    in_item_t    w;
    int unsigned roll;
    w = word(OPC_WRITE, 8'($urandom_range(0, 255)), 13'($urandom_range(0, 8191)),
             12'($urandom_range(0, 4095)));
    roll = $urandom_range(0, 99);
    if (roll >= 45 && roll < 66) begin
      w.opcode = OPC_POP;
      if (roll < 56) begin
        w.pop_count = 13'($urandom_range(0, (gen_held < 4) ? gen_held : 4));
      end else if (roll < 63) begin
        w.pop_count = 13'($urandom_range(0, gen_held));
      end
    end else if (roll >= 66 && roll < 95) begin
      w.opcode = OPC_PEEK;
      if (gen_held != 0 && roll < 91) w.peek_index = 12'($urandom_range(0, gen_held - 1));
    end else if (roll >= 95) begin
      w.opcode = OPC_END;
    end
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 200) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic compare_status(out_item_t got, out_item_t want);
    check_field("accepted", 32'(got.accepted), 32'(want.accepted));
    check_field("peek_data", 32'(got.peek_data), 32'(want.peek_data));
    check_field("range_error", 32'(got.range_error), 32'(want.range_error));
    check_field("buffered", 32'(got.buffered), 32'(want.buffered));
    check_field("room_left", 32'(got.room_left), 32'(want.room_left));
    check_field("written_total", got.written_total, want.written_total);
    check_field("read_total", got.read_total, want.read_total);
    check_field("input_closed", 32'(got.input_closed), 32'(want.input_closed));
    check_field("stream_done", 32'(got.stream_done), 32'(want.stream_done));
  endtask

  task automatic issue(in_item_t w, bit may_idle = 1'b1, bit pin = 1'b0,
                       out_item_t want = '0);
    case (w.opcode)
      OPC_WRITE: if (gen_held < gen_lim) gen_held++;
      OPC_POP:   if (w.pop_count <= gen_held) gen_held -= w.pop_count;
      default:   ;
    endcase
    pinned_slots[pin_wr] = '{on: pin, want: want};
    pin_wr = (pin_wr + 1) % RING_SIZE;
    if (may_idle && gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (aw_count != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [12:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    gen_lim = (v < STORE_DEPTH) ? v : STORE_DEPTH;
  endtask

  // check results, then advance the model on accepted command words
  always @(posedge clk_i) begin : watch_words
    out_item_t pred;
    pin_t      pin;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (aw_count == 0) begin
          report_mismatch("status word with nothing awaited");
        end else begin
          compare_status(out_data_o, awaited_status[aw_head]);
          aw_head = (aw_head + 1) % RING_SIZE;
          aw_count--;
        end
      end
      if (cfg_valid_i && cfg_ready_o) cap_reg = 32'(cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        pred   = stream_step(in_data_i);
        pin    = pinned_slots[pin_rd];
        pin_rd = (pin_rd + 1) % RING_SIZE;
        awaited_status[aw_tail] = pin.on ? pin.want : pred;
        aw_tail = (aw_tail + 1) % RING_SIZE;
        aw_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (park_req) begin
      park_left = PARK_CYCLES;
      park_req  = 1'b0;
    end
    if (park_left > 0) begin
      park_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_n = 0;
      end else begin
        quiet_n++;
      end
      if (quiet_n >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [12:0] next_cap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(pinned(word(OPC_PEEK, 8'h00, 13'd0, 12'd0),
                   status(0, 8'h00, 1, 0, 4096, 0, 0, 0, 0)));
    add_row(pinned(word(OPC_POP, 8'h00, 13'd1, 12'd0),
                   status(0, 8'h00, 1, 0, 4096, 0, 0, 0, 0)));
    add_row(pinned(word(OPC_POP, 8'hFF, 13'd0, 12'hFFF),
                   status(0, 8'h00, 0, 0, 4096, 0, 0, 0, 0)));
    add_row(pinned(word(OPC_END, 8'h00, 13'd0, 12'd0),
                   status(0, 8'h00, 0, 0, 4096, 0, 0, 1, 1)));
    add_row(pinned(word(OPC_WRITE, 8'h00, 13'h1FFF, 12'd0),
                   status(1, 8'h00, 0, 1, 4095, 1, 0, 1, 0)));
    add_row(pinned(word(OPC_WRITE, 8'hFF, 13'd0, 12'hFFF),
                   status(1, 8'h00, 0, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_PEEK, 8'h00, 13'd0, 12'd1),
                   status(0, 8'hFF, 0, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_PEEK, 8'hFF, 13'h1FFF, 12'd0),
                   status(0, 8'h00, 0, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_PEEK, 8'h00, 13'd0, 12'd2),
                   status(0, 8'h00, 1, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_PEEK, 8'h00, 13'd0, 12'hFFF),
                   status(0, 8'h00, 1, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_POP, 8'h00, 13'd3, 12'd0),
                   status(0, 8'h00, 1, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_POP, 8'h00, 13'h1FFF, 12'd0),
                   status(0, 8'h00, 1, 2, 4094, 2, 0, 1, 0)));
    add_row(pinned(word(OPC_END, 8'hFF, 13'h1FFF, 12'hFFF),
                   status(0, 8'h00, 0, 2, 4094, 2, 0, 1, 0)));
    add_row(cap_row(13'd1));
    add_row(pinned(word(OPC_WRITE, 8'hA5, 13'd0, 12'd0),
                   status(0, 8'h00, 0, 2, 0, 2, 0, 1, 0)));
    add_row(cap_row(13'd0));
    add_row(pinned(word(OPC_POP, 8'h00, 13'd1, 12'd0),
                   status(0, 8'h00, 0, 1, 0, 2, 1, 1, 0)));
    add_row(pinned(word(OPC_PEEK, 8'h00, 13'd0, 12'd0),
                   status(0, 8'hFF, 0, 1, 0, 2, 1, 1, 0)));
    add_row(pinned(word(OPC_POP, 8'h00, 13'd1, 12'd0),
                   status(0, 8'h00, 0, 0, 0, 2, 2, 1, 1)));
    add_row(pinned(word(OPC_WRITE, 8'h3C, 13'd0, 12'd0),
                   status(0, 8'h00, 0, 0, 0, 2, 2, 1, 1)));
    add_row(cap_row(13'h1FFF));
    add_row(pinned(word(OPC_WRITE, 8'h5A, 13'd0, 12'd0),
                   status(1, 8'h00, 0, 1, 4095, 3, 2, 1, 0)));
    add_row(cap_row(13'd2));
    add_row(plain(word(OPC_WRITE, 8'h81, 13'd0, 12'd0)));
    add_row(plain(word(OPC_WRITE, 8'h7E, 13'd0, 12'd0)));
    add_row(plain(word(OPC_PEEK, 8'h00, 13'd0, 12'd1)));
    add_row(plain(word(OPC_POP, 8'h00, 13'd2, 12'd0)));

    for (int unsigned i = 0; i < plan_n; i++) begin
      if (plan_rows[i].is_cfg) set_capacity(plan_rows[i].cap);
      else issue(plan_rows[i].word, 1'b1, plan_rows[i].pinned, plan_rows[i].want);
    end

    // hold off the receiver through a long run of writes from an offset head
    set_capacity(13'd4096);
    issue(word(OPC_POP, 8'h00, 13'(gen_held), 12'd0));
    park_req = 1'b1;
    repeat (40) issue(word(OPC_WRITE, 8'($urandom_range(0, 255)), 13'd0, 12'd0), 1'b0);
    repeat (260) issue(word(OPC_WRITE, 8'($urandom_range(0, 255)), 13'd0, 12'd0));
    issue(word(OPC_POP, 8'h00, 13'd123, 12'd0));
    issue(word(OPC_PEEK, 8'h00, 13'd0, 12'hFFF));
    issue(word(OPC_PEEK, 8'h00, 13'd0, 12'($urandom_range(0, 4095))));
    issue(word(OPC_POP, 8'h00, 13'(gen_held), 12'd0));

    for (int p = 0; p < 16; p++) begin
      case (p % 8)
        0:       next_cap = 13'd0;
        1:       next_cap = 13'd1;
        2:       next_cap = 13'd4096;
        3:       next_cap = 13'h1FFF;
        4:       next_cap = 13'd4095;
        5:       next_cap = 13'($urandom_range(0, 8191));
        default: next_cap = 13'($urandom_range(1, 40));
      endcase
      gaps_on = (p == 15) ? 1'b0 : ($urandom_range(0, 3) != 0);
      set_capacity(next_cap);
      repeat (39) issue(pick_word());
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
